FILE: hdl/glmd_pkg.sv
// ----------------------------------------------------------------------------
// Grid local maximum detector: shared package
// Types, sizes and the neighbourhood compare used by the detector modules.
// ----------------------------------------------------------------------------
package glmd_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_LIMIT   = 4096;
    localparam int ROW_BITS    = $clog2(ROW_LIMIT);
    localparam int NROWS_BITS  = 13;
    localparam int NCOLS_BITS  = 11;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ROWS = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLS = 8'd1;

    // Result queue of per-pixel decision records.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Decision bits of one pixel, in reporting order.
    localparam int DEC_UL = 0;  // cell one row up, one column left
    localparam int DEC_UP = 1;  // cell one row up, same column (row end)
    localparam int DEC_LF = 2;  // cell same row, one column left (last row)
    localparam int DEC_HR = 3;  // the pixel itself (end of frame)

    typedef logic signed [PIXEL_BITS-1:0] t_pix;
    typedef t_pix t_win [3][3];
    typedef logic [2*PIXEL_BITS-1:0] t_line_word;

    typedef struct packed {
        logic [3:0]          mask;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_peak_rec;

    // True when the centre at (cr, ck) is strictly above every neighbour
    // that exists on the sides flagged as present.
    function automatic logic is_peak(input t_win w, input int cr, input int ck,
                                     input logic top_ok, input logic left_ok,
                                     input logic bot_ok, input logic right_ok);
        logic ok;
        int   ri;
        int   kj;
        ok = 1'b1;
        for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
                ri = cr + di;
                kj = ck + dj;
                if (!(di == 0 && dj == 0) && ri >= 0 && ri <= 2 && kj >= 0 && kj <= 2 &&
                    !(di < 0 && !top_ok) && !(di > 0 && !bot_ok) &&
                    !(dj < 0 && !left_ok) && !(dj > 0 && !right_ok)) begin
                    if (!(w[cr][ck] > w[ri][kj])) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

FILE: hdl/glmd_out_queue.sv
// ----------------------------------------------------------------------------
// Grid local maximum detector: result queue
// Buffers per-pixel decision records and hands out one maximum per transfer.
// ----------------------------------------------------------------------------
module glmd_out_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  glmd_pkg::t_peak_rec           i_rec,
    output logic                          o_room,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [glmd_pkg::ROW_BITS-1:0] o_max_row,
    output logic [glmd_pkg::COL_BITS-1:0] o_max_col,
    output logic                          o_last
);

    glmd_pkg::t_peak_rec r_mem [glmd_pkg::QUEUE_DEPTH];
    logic [glmd_pkg::QUEUE_AW-1:0] r_wr;
    logic [glmd_pkg::QUEUE_AW-1:0] r_rd;
    logic [glmd_pkg::QUEUE_AW:0]   r_cnt;
    glmd_pkg::t_peak_rec           r_cur;
    logic                          r_cur_valid;

    logic       xfer;
    logic       one_left;
    logic       load;
    logic [3:0] low_bit;

    // One record in flight upstream plus the one being accepted must fit.
    assign o_room = (r_cnt <= (glmd_pkg::QUEUE_AW+1)'(glmd_pkg::QUEUE_DEPTH - 2));

    assign low_bit  = r_cur.mask & (~r_cur.mask + 4'd1);
    assign one_left = (r_cur.mask & (r_cur.mask - 4'd1)) == 4'd0;
    assign xfer     = r_cur_valid && i_ready;
    assign load     = (r_cnt != '0) && (!r_cur_valid || (xfer && one_left));

    assign o_valid   = r_cur_valid;
    assign o_last    = one_left;
    assign o_max_row = (low_bit[glmd_pkg::DEC_UL] || low_bit[glmd_pkg::DEC_UP])
                       ? r_cur.row - 1'b1 : r_cur.row;
    assign o_max_col = (low_bit[glmd_pkg::DEC_UL] || low_bit[glmd_pkg::DEC_LF])
                       ? r_cur.col - 1'b1 : r_cur.col;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_cnt       <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (load) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (glmd_pkg::QUEUE_AW+1)'(i_push) - (glmd_pkg::QUEUE_AW+1)'(load);
            if (load) begin
                r_cur       <= r_mem[r_rd];
                r_cur_valid <= 1'b1;
            end else if (xfer && one_left) begin
                r_cur_valid <= 1'b0;
            end else if (xfer) begin
                r_cur.mask <= r_cur.mask & ~low_bit;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < (glmd_pkg::QUEUE_AW+1)'(glmd_pkg::QUEUE_DEPTH)))
        else $error("result queue written while full");
    a_cur_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_cur.mask != 4'd0))
        else $error("current record holds no decision");
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_rec.mask != 4'd0))
        else $error("empty record pushed");
`endif

endmodule

FILE: hdl/grid_local_maximum_detector_unit.sv
// ----------------------------------------------------------------------------
// Grid local maximum detector
// Streams raster-order grid values and reports every strict 8-neighbour peak.
// ----------------------------------------------------------------------------
// One pixel is taken per clock cycle. Each pixel reads and rewrites one entry
// of a single line memory that holds the two previous rows side by side; the
// read is registered, and a pixel that hits the entry still being rewritten
// by its predecessor (one-column grids) is served by forwarding. A cell is
// decided one row and one column after it arrives. A pixel may decide up to
// four cells; results leave one per transfer in raster order, but the last
// two rows interleave by column. The input stalls only while the eight-entry
// result queue is close to full, which happens when row ends and the last
// row produce results faster than the output drains them. No clearing pass
// follows reset.
module grid_local_maximum_detector_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [glmd_pkg::PIXEL_BITS-1:0]    i_pixel_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [glmd_pkg::ROW_BITS-1:0]      o_max_row,
    output logic [glmd_pkg::COL_BITS-1:0]      o_max_col,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [glmd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [glmd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int P = glmd_pkg::PIXEL_BITS;

    logic [glmd_pkg::NROWS_BITS-1:0] r_num_rows;
    logic [glmd_pkg::NCOLS_BITS-1:0] r_num_cols;
    logic [glmd_pkg::ROW_BITS-1:0]   r_row;
    logic [glmd_pkg::COL_BITS-1:0]   r_col;

    glmd_pkg::t_line_word r_line [glmd_pkg::MAX_COLS];
    glmd_pkg::t_line_word r_rd_data;
    glmd_pkg::t_line_word r_fwd_data;
    logic                 r_fwd;

    logic                          r_b_valid;
    glmd_pkg::t_pix                r_b_px;
    logic [glmd_pkg::ROW_BITS-1:0] r_b_row;
    logic [glmd_pkg::COL_BITS-1:0] r_b_col;
    logic                          r_b_endc;
    logic                          r_b_endr;

    glmd_pkg::t_win r_win;
    glmd_pkg::t_win n_win;

    logic                          accept;
    logic                          room;
    logic [glmd_pkg::ROW_BITS-1:0] rows_m1;
    logic [glmd_pkg::COL_BITS-1:0] cols_m1;
    logic                          endc;
    logic                          endr;
    glmd_pkg::t_line_word          line_word;
    glmd_pkg::t_pix                up_px;
    glmd_pkg::t_pix                mid_px;
    logic                          r_ge1;
    logic                          r_ge2;
    logic                          c_ge1;
    logic                          c_ge2;
    glmd_pkg::t_peak_rec           rec;
    logic                          push;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = room;
    assign accept      = i_valid && room;

    // Out-of-range sizes are clamped to the supported grid.
    always_comb begin
        if (r_num_rows == '0) begin
            rows_m1 = '0;
        end else if (r_num_rows > glmd_pkg::NROWS_BITS'(glmd_pkg::ROW_LIMIT)) begin
            rows_m1 = glmd_pkg::ROW_BITS'(glmd_pkg::ROW_LIMIT - 1);
        end else begin
            rows_m1 = glmd_pkg::ROW_BITS'(r_num_rows - 1'b1);
        end
        if (r_num_cols == '0) begin
            cols_m1 = '0;
        end else if (r_num_cols > glmd_pkg::NCOLS_BITS'(glmd_pkg::MAX_COLS)) begin
            cols_m1 = glmd_pkg::COL_BITS'(glmd_pkg::MAX_COLS - 1);
        end else begin
            cols_m1 = glmd_pkg::COL_BITS'(r_num_cols - 1'b1);
        end
    end

    assign endc = r_col >= cols_m1;
    assign endr = r_row >= rows_m1;

    // Upper line in the high half, middle line in the low half.
    assign line_word = r_fwd ? r_fwd_data : r_rd_data;
    assign up_px     = line_word[2*P-1:P];
    assign mid_px    = line_word[P-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = up_px;
        n_win[1][2] = mid_px;
        n_win[2][2] = r_b_px;
    end

    assign r_ge1 = r_b_row != '0;
    assign r_ge2 = r_b_row > glmd_pkg::ROW_BITS'(1);
    assign c_ge1 = r_b_col != '0;
    assign c_ge2 = r_b_col > glmd_pkg::COL_BITS'(1);

    always_comb begin
        rec.row = r_b_row;
        rec.col = r_b_col;
        rec.mask[glmd_pkg::DEC_UL] = r_ge1 && c_ge1 &&
            glmd_pkg::is_peak(n_win, 1, 1, r_ge2, c_ge2, 1'b1, 1'b1);
        rec.mask[glmd_pkg::DEC_UP] = r_ge1 && r_b_endc &&
            glmd_pkg::is_peak(n_win, 1, 2, r_ge2, c_ge1, 1'b1, 1'b0);
        rec.mask[glmd_pkg::DEC_LF] = r_b_endr && c_ge1 &&
            glmd_pkg::is_peak(n_win, 2, 1, r_ge1, c_ge2, 1'b0, 1'b1);
        rec.mask[glmd_pkg::DEC_HR] = r_b_endr && r_b_endc &&
            glmd_pkg::is_peak(n_win, 2, 2, r_ge1, c_ge1, 1'b0, 1'b0);
    end

    assign push = r_b_valid && (rec.mask != 4'd0);

    // Line memory: read at acceptance, written back in the cycle after.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_line[r_col];
        end
        if (r_b_valid) begin
            r_line[r_b_col] <= {mid_px, r_b_px};
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= {mid_px, r_b_px};
        if (accept) begin
            r_b_px   <= glmd_pkg::t_pix'(i_pixel_value);
            r_b_row  <= r_row;
            r_b_col  <= r_col;
            r_b_endc <= endc;
            r_b_endr <= endr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= glmd_pkg::NROWS_BITS'(2);
            r_num_cols <= glmd_pkg::NCOLS_BITS'(2);
            r_row      <= '0;
            r_col      <= '0;
            r_b_valid  <= 1'b0;
            r_fwd      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    glmd_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    glmd_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data[glmd_pkg::NCOLS_BITS-1:0];
                    default: ;
                endcase
            end
            r_b_valid <= accept;
            r_fwd     <= accept && r_b_valid && (r_col == r_b_col);
            if (accept) begin
                if (endc) begin
                    r_col <= '0;
                    r_row <= endr ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_b_valid) begin
                r_win <= n_win;
            end
        end
    end

    glmd_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rec     (rec),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_max_row (o_max_row),
        .o_max_col (o_max_col),
        .o_last    (o_last)
    );

`ifndef NO_ASSERTIONS
    a_fwd_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_b_valid)
        else $error("forwarding without a preceding pixel");
    a_accept_reaches_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_valid)
        else $error("accepted pixel did not reach the decision stage");
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && endc) |=> (r_col == '0))
        else $error("column counter did not wrap at row end");
`endif

endmodule
